@@ sv/button_debounce_press_classifier_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Button debounce press classifier - assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_ASSERT_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication
`define BDPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bdpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bdpc_pkg
// Types and constants shared by the button debounce press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int unsigned BtnCount  = 5;
  localparam int unsigned CenterIdx = 4;
  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned TimeWidth = 32;

  localparam logic [CfgWidth-1:0] DebounceRst = 16'd50;
  localparam logic [CfgWidth-1:0] ShortMaxRst = 16'd500;
  localparam logic [CfgWidth-1:0] LongRst     = 16'd1000;

  typedef enum logic [0:0] {
    OpPoll = 1'b0,
    OpInit = 1'b1
  } bdpc_op_e;

  typedef enum logic [1:0] {
    CfgDebounce = 2'd0,
    CfgShortMax = 2'd1,
    CfgLong     = 2'd2
  } bdpc_cfg_idx_e;

  typedef enum logic [2:0] {
    EvNone   = 3'd0,
    EvLeft   = 3'd1,
    EvRight  = 3'd2,
    EvUp     = 3'd3,
    EvDown   = 3'd4,
    EvShort  = 3'd5,
    EvLong   = 3'd6
  } bdpc_event_e;

  typedef struct packed {
    logic [CfgWidth-1:0] debounce_ms;
    logic [CfgWidth-1:0] short_max_ms;
    logic [CfgWidth-1:0] long_ms;
  } bdpc_cfg_t;

  typedef struct packed {
    bdpc_op_e               operation;
    logic [BtnCount-1:0]    levels;
    logic [TimeWidth-1:0]   now_ms;
  } bdpc_item_t;

  // direction button index to its event code
  function automatic bdpc_event_e dir_event(input logic [2:0] idx);
    bdpc_event_e ev;
    case (idx)
      3'd0:    ev = EvLeft;
      3'd1:    ev = EvRight;
      3'd2:    ev = EvUp;
      3'd3:    ev = EvDown;
      default: ev = EvNone;
    endcase
    return ev;
  endfunction

endpackage

@@ sv/bdpc_core.sv @@
// ----------------------------------------------------------------------------
// bdpc_core
// Debounce state per button and single-pass priority scan of one poll.
// ----------------------------------------------------------------------------
module bdpc_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  bdpc_pkg::bdpc_item_t    item_i,
  input  bdpc_pkg::bdpc_cfg_t     cfg_i,
  output bdpc_pkg::bdpc_event_e   event_o
);
  import bdpc_pkg::*;

  logic [BtnCount-1:0]  stable_q, stable_d;
  logic [TimeWidth-1:0] last_q [BtnCount];
  logic [TimeWidth-1:0] last_d [BtnCount];
  logic [TimeWidth-1:0] press_q, press_d;
  logic                 long_rep_q, long_rep_d;

  bdpc_event_e          ev;
  logic                 done;
  logic [TimeWidth-1:0] since [BtnCount];
  logic [TimeWidth-1:0] held;
  logic                 cur;

  always_comb begin
    for (int i = 0; i < BtnCount; i++) begin
      since[i] = item_i.now_ms - last_q[i];
    end
    held = item_i.now_ms - press_q;
  end

  always_comb begin
    stable_d   = stable_q;
    last_d     = last_q;
    press_d    = press_q;
    long_rep_d = long_rep_q;
    ev         = EvNone;
    done       = 1'b0;
    cur        = 1'b1;
    if (item_i.operation == OpInit) begin
      stable_d = item_i.levels;
      for (int i = 0; i < BtnCount; i++) begin
        last_d[i] = item_i.now_ms;
      end
      press_d    = '0;
      long_rep_d = 1'b0;
    end else begin
      // first button with an event wins; the rest wait for the next poll
      for (int i = 0; i < BtnCount; i++) begin
        cur = item_i.levels[i];
        if (!done) begin
          if (cur != stable_q[i]) begin
            if (since[i] > {{(TimeWidth-CfgWidth){1'b0}}, cfg_i.debounce_ms}) begin
              stable_d[i] = cur;
              last_d[i]   = item_i.now_ms;
              if (!cur) begin
                if (i == CenterIdx) begin
                  press_d    = item_i.now_ms;
                  long_rep_d = 1'b0;
                end else begin
                  ev   = dir_event(3'(i));
                  done = 1'b1;
                end
              end else if (i == CenterIdx && !long_rep_q) begin
                if (held < {{(TimeWidth-CfgWidth){1'b0}}, cfg_i.short_max_ms}) begin
                  ev   = EvShort;
                  done = 1'b1;
                end else if (held >= {{(TimeWidth-CfgWidth){1'b0}}, cfg_i.long_ms}) begin
                  ev   = EvLong;
                  done = 1'b1;
                end
              end
            end
          end else if (i == CenterIdx && !stable_q[i] && !long_rep_q) begin
            // held past the long limit: report once
            if (held >= {{(TimeWidth-CfgWidth){1'b0}}, cfg_i.long_ms}) begin
              long_rep_d = 1'b1;
              ev         = EvLong;
              done       = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q   <= '1;
      press_q    <= '0;
      long_rep_q <= 1'b0;
      for (int i = 0; i < BtnCount; i++) begin
        last_q[i] <= '0;
      end
    end else if (fire_i) begin
      stable_q   <= stable_d;
      press_q    <= press_d;
      long_rep_q <= long_rep_d;
      last_q     <= last_d;
    end
  end

  assign event_o = ev;

endmodule

@@ sv/button_debounce_press_classifier_unit.sv @@
// Path: an accepted input beat goes into the input register, its result into the
// result register on m_axis. Throughput: one poll per cycle unless m_axis stalls;
// the scan is one combinational pass between them, state updated as it leaves.
// Reset: buttons released, change and press times zero, no long press
// pending, registers back to 50 / 500 / 1000 ms, both stages empty.
// ----------------------------------------------------------------------------
// button_debounce_press_classifier_unit
// Five-button debouncer with direction events and center short/long press.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [4:0] levels, [36:5] now_ms, [39:37] zero
  input  logic [0:0]  s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [2:0] event_res, [7:3] zero
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import bdpc_pkg::*;

  bdpc_cfg_t   cfg_q;
  logic        s1_valid_q, s1_valid_d;
  bdpc_item_t  s1_item_q;
  logic        s2_valid_q;
  bdpc_event_e s2_event_q;
  bdpc_event_e core_event;
  logic        s_accept;
  logic        advance;

  assign advance       = !s2_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms  <= DebounceRst;
      cfg_q.short_max_ms <= ShortMaxRst;
      cfg_q.long_ms      <= LongRst;
    end else if (cfg_we_i) begin
      case (bdpc_cfg_idx_e'(cfg_idx_i))
        CfgDebounce: cfg_q.debounce_ms  <= cfg_data_i;
        CfgShortMax: cfg_q.short_max_ms <= cfg_data_i;
        CfgLong:     cfg_q.long_ms      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (advance) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_item_q.operation <= bdpc_op_e'(s_axis_tuser[0]);
      s1_item_q.levels    <= s_axis_tdata[4:0];
      s1_item_q.now_ms    <= s_axis_tdata[36:5];
    end
    if (advance && s1_valid_q) begin
      s2_event_q <= core_event;
    end
  end

  bdpc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (s1_valid_q && advance),
    .item_i  (s1_item_q),
    .cfg_i   (cfg_q),
    .event_o (core_event)
  );

  assign m_axis_tvalid = s2_valid_q;
  assign m_axis_tdata  = {5'b0, s2_event_q};

endmodule

@@ sv/bdpc_checker.sv @@
// ----------------------------------------------------------------------------
// bdpc_checker
// Port-level checks for the button debounce press classifier.
// ----------------------------------------------------------------------------
`include "button_debounce_press_classifier_unit_assert.svh"

module bdpc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        cfg_we_i
);
  import bdpc_pkg::*;

  logic [1:0] pend_q;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  // polls accepted whose result beat has not gone out yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_beat) - 2'(out_beat);
    end
  end

  `BDPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat dropped or changed while stalled")
  `BDPC_ASSERT_IMPL(a_no_orphan, m_axis_tvalid, pend_q != 2'd0, "result beat without an accepted poll")
  `BDPC_ASSERT_IMPL(a_stall_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")
  `BDPC_ASSERT_IMPL(a_event_code, m_axis_tvalid, m_axis_tdata[7:3] == 5'd0 && m_axis_tdata[2:0] <= 3'(EvLong), "bad event code")
  // register writes must land only while the pipeline is empty; the unit does not enforce it, this check flags it
  `BDPC_ASSERT_IMPL(a_cfg_idle, cfg_we_i, pend_q == 2'd0, "register write with polls in flight")

endmodule

bind button_debounce_press_classifier_unit bdpc_checker u_bdpc_checker (.*);
